/* rtl/core/motor_command_framer_crc7_defines.svh */
// Assertion macros used by the command framer RTL.
`ifndef MOTOR_COMMAND_FRAMER_CRC7_DEFINES_SVH
`define MOTOR_COMMAND_FRAMER_CRC7_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define MCF_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define MCF_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/core/mcf_pkg.sv */
// Types, codes and the CRC-7 step for the motor command framer.
package mcf_pkg;

    typedef enum logic [2:0] {
        ACT_EXIT_SAFE  = 3'd0,
        ACT_SET_SPEED  = 3'd1,
        ACT_STOP       = 3'd2,
        ACT_READ_VAR   = 3'd3,
        ACT_SET_LIMIT  = 3'd4,
        ACT_REPLY_BYTE = 3'd5
    } t_action;

    typedef enum logic [1:0] {
        KIND_TX    = 2'd0,
        KIND_VAR   = 2'd1,
        KIND_LIMIT = 2'd2
    } t_kind;

    typedef enum logic [1:0] {
        STAT_OK        = 2'd0,
        STAT_CRC_BAD   = 2'd1,
        STAT_STRAY     = 2'd2,
        STAT_LIMIT_REJ = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        EXP_NONE  = 2'd0,
        EXP_LIMIT = 2'd1,
        EXP_VAR   = 2'd2
    } t_expect;

    typedef enum logic [1:0] {
        EM_IDLE = 2'd0,
        EM_BODY = 2'd1,
        EM_TAIL = 2'd2
    } t_emit_st;

    localparam logic [7:0]  CRC_POLY_REFL = 8'h91;
    localparam logic [7:0]  CMD_EXIT_SAFE = 8'h83;
    localparam logic [7:0]  CMD_FWD       = 8'h85;
    localparam logic [7:0]  CMD_REV       = 8'h86;
    localparam logic [7:0]  CMD_STOP      = 8'hE0;
    localparam logic [7:0]  CMD_READ_VAR  = 8'hA1;
    localparam logic [7:0]  CMD_SET_LIMIT = 8'hA2;
    localparam logic [12:0] SPEED_MAX     = 13'd3200;
    localparam logic [6:0]  VAR_SIGNED_A  = 7'd20;
    localparam logic [6:0]  VAR_SIGNED_B  = 7'd21;

    typedef struct packed {
        logic [2:0]  action;
        logic [12:0] speed;        // two's complement
        logic [6:0]  var_num;
        logic [3:0]  lim_num;
        logic [13:0] limit_value;
        logic [7:0]  rx_byte;
    } t_item;

    typedef struct packed {
        t_kind       kind;
        logic [7:0]  tx_byte;
        logic        last;
        logic [16:0] reply_value;  // two's complement
        t_status     status;
    } t_beat;

    typedef struct packed {
        logic        has_beat;
        t_kind       kind;
        logic [16:0] value;
        t_status     status;
    } t_reply_res;

    // One byte through the reflected CRC-7, LSB first.
    function automatic logic [6:0] crc7_step(input logic [6:0] c, input logic [7:0] b);
        logic [7:0] v;
        v = {1'b0, c} ^ b;
        for (int k = 0; k < 8; k++) begin
            if (v[0]) begin
                v = v ^ CRC_POLY_REFL;
            end
            v = v >> 1;
        end
        return v[6:0];
    endfunction

endpackage

/* rtl/core/motor_command_framer_crc7.sv */
// Top level of the motor command framer with CRC-7 reply checking.
//
//  channel  | dir | tdata                                          | tuser  | tlast
//  ---------+-----+------------------------------------------------+--------+------
//  s (cmd)  | in  | speed, var_num, lim_num, limit_value, rx_byte  | action | -
//  m (res)  | out | tx_byte, reply_value, status                   | kind   | last
//
//  A command of n bytes goes out as n+1 beats (2 to 5), the CRC byte last; the
//  emitter sends one byte per cycle through one output register while not stalled.
//  A reply byte yields at most one beat.
//  Reset (synchronous, active low) drops any pending reply and empties both stages.
//  A stalled output holds its beat; one command waits in the input register meanwhile.
`include "motor_command_framer_crc7_defines.svh"

module motor_command_framer_crc7 (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    // [12:0] speed, [19:13] var_num, [23:20] lim_num,
    // [37:24] limit_value, [45:38] rx_byte, [47:46] zero
    input  logic [47:0] i_s_tdata,
    // [2:0] action
    input  logic [2:0]  i_s_tuser,
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    // [7:0] tx_byte, [24:8] reply_value, [26:25] status, [31:27] zero
    output logic [31:0] o_m_tdata,
    // [1:0] kind
    output logic [1:0]  o_m_tuser,
    output logic        o_m_tlast
);
    import mcf_pkg::*;

    t_item      in_item;
    t_item      item;
    logic       item_valid;
    logic       take;
    logic       emit_busy;
    t_reply_res reply;
    t_beat      beat;
    logic       res_tx;
    logic       res_reply;

    // Unpack the slave beat into the item fields.
    assign in_item = '{action:      i_s_tuser,
                       speed:       i_s_tdata[12:0],
                       var_num:     i_s_tdata[19:13],
                       lim_num:     i_s_tdata[23:20],
                       limit_value: i_s_tdata[37:24],
                       rx_byte:     i_s_tdata[45:38]};

    mcf_ingress u_ingress (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_s_tvalid),
        .o_ready (o_s_tready),
        .i_item  (in_item),
        .i_take  (take),
        .o_valid (item_valid),
        .o_item  (item)
    );

    // Reply state advances only when the emitter takes the held item.
    mcf_reply u_reply (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_item  (item),
        .i_take  (take),
        .o_res   (reply)
    );

    mcf_emit u_emit (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_item_valid (item_valid),
        .i_item       (item),
        .i_reply      (reply),
        .o_take       (take),
        .o_busy       (emit_busy),
        .o_beat_valid (o_m_tvalid),
        .i_beat_ready (i_m_tready),
        .o_beat       (beat)
    );

    // Pack the result beat.
    assign o_m_tdata = {5'd0, beat.status, beat.reply_value, beat.tx_byte};
    assign o_m_tuser = beat.kind;
    assign o_m_tlast = beat.last;

    // Valid result beat that carries a transmit byte or a reply result.
    assign res_tx    = o_m_tvalid && (o_m_tuser == KIND_TX);
    assign res_reply = o_m_tvalid && (o_m_tuser != KIND_TX);

    `MCF_ASSERT_IMP(a_result_last, i_clk, i_rst_n, res_reply, o_m_tlast, "result lacks tlast")
    `MCF_ASSERT_IMP(a_tx_clean, i_clk, i_rst_n, res_tx, o_m_tdata[31:8] == 24'd0, "tx beat unclean")
    `MCF_ASSERT_IMP(a_no_take_busy, i_clk, i_rst_n, emit_busy, !take, "item taken mid-frame")
    `MCF_ASSERT_NXT(a_frame_cont, i_clk, i_rst_n, res_tx && i_m_tready && !o_m_tlast, res_tx, "frame broken")

endmodule

/* rtl/core/mcf_ingress.sv */
// Input holding register for the command framer.
module mcf_ingress (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_ready,
    input  mcf_pkg::t_item i_item,
    input  logic           i_take,
    output logic           o_valid,
    output mcf_pkg::t_item o_item
);
    import mcf_pkg::*;

    logic  r_valid;
    t_item r_item;

    assign o_ready = !r_valid || i_take;
    assign o_valid = r_valid;
    assign o_item  = r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_valid && o_ready) begin
            r_valid <= 1'b1;
        end else if (i_take) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_item <= i_item;
        end
    end

endmodule

/* rtl/core/mcf_reply.sv */
// Reply tracker: collects reply bytes, checks the CRC and forms the result.
module mcf_reply (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  mcf_pkg::t_item      i_item,
    input  logic                i_take,
    output mcf_pkg::t_reply_res o_res
);
    import mcf_pkg::*;

    logic [6:0] r_crc, n_crc;
    logic [1:0] r_count, n_count;
    t_expect    r_expected, n_expected;
    logic [7:0] r_low, n_low;
    logic [7:0] r_high, n_high;
    logic       r_signed, n_signed;
    logic       r_limit, n_limit;

    t_action     act;
    logic [15:0] word;
    logic [16:0] var_value;

    assign act       = t_action'(i_item.action);
    assign word      = {r_high, r_low};
    assign var_value = (r_signed && word[15]) ? {1'b1, word} : {1'b0, word};

    always_comb begin
        n_crc      = r_crc;
        n_count    = r_count;
        n_expected = r_expected;
        n_low      = r_low;
        n_high     = r_high;
        n_signed   = r_signed;
        n_limit    = r_limit;
        o_res      = '{has_beat: 1'b0, kind: KIND_VAR, value: '0, status: STAT_OK};
        case (act)
            ACT_EXIT_SAFE, ACT_SET_SPEED, ACT_STOP: begin
                n_crc      = '0;
                n_count    = '0;
                n_expected = EXP_NONE;
                n_signed   = 1'b0;
                n_limit    = 1'b0;
            end
            ACT_READ_VAR: begin
                n_crc      = '0;
                n_count    = '0;
                n_expected = EXP_VAR;
                n_signed   = (i_item.var_num == VAR_SIGNED_A) ||
                             (i_item.var_num == VAR_SIGNED_B);
                n_limit    = 1'b0;
            end
            ACT_SET_LIMIT: begin
                n_crc      = '0;
                n_count    = '0;
                n_expected = EXP_LIMIT;
                n_signed   = 1'b0;
                n_limit    = 1'b1;
            end
            ACT_REPLY_BYTE: begin
                if (r_expected == EXP_NONE) begin
                    o_res.has_beat = 1'b1;
                    o_res.status   = STAT_STRAY;
                end else if (r_count < r_expected) begin
                    if (r_count == 2'd0) begin
                        n_low = i_item.rx_byte;
                    end else begin
                        n_high = i_item.rx_byte;
                    end
                    n_crc   = crc7_step(r_crc, i_item.rx_byte);
                    n_count = r_count + 2'd1;
                end else begin
                    o_res.has_beat = 1'b1;
                    o_res.kind     = r_limit ? KIND_LIMIT : KIND_VAR;
                    if (i_item.rx_byte != {1'b0, r_crc}) begin
                        o_res.status = STAT_CRC_BAD;
                    end else if (r_limit) begin
                        o_res.value  = {9'd0, r_low};
                        o_res.status = (r_low != 8'd0) ? STAT_LIMIT_REJ : STAT_OK;
                    end else begin
                        o_res.value = var_value;
                    end
                    n_crc      = '0;
                    n_count    = '0;
                    n_expected = EXP_NONE;
                    n_signed   = 1'b0;
                    n_limit    = 1'b0;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_crc      <= '0;
            r_count    <= '0;
            r_expected <= EXP_NONE;
            r_signed   <= 1'b0;
            r_limit    <= 1'b0;
        end else if (i_take) begin
            r_crc      <= n_crc;
            r_count    <= n_count;
            r_expected <= n_expected;
            r_signed   <= n_signed;
            r_limit    <= n_limit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_take) begin
            r_low  <= n_low;
            r_high <= n_high;
        end
    end

endmodule

/* rtl/core/mcf_emit.sv */
// Frame encoder and byte sequencer with the output beat register.
module mcf_emit (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_item_valid,
    input  mcf_pkg::t_item      i_item,
    input  mcf_pkg::t_reply_res i_reply,
    output logic                o_take,
    output logic                o_busy,
    output logic                o_beat_valid,
    input  logic                i_beat_ready,
    output mcf_pkg::t_beat      o_beat
);
    import mcf_pkg::*;

    t_emit_st   r_state, n_state;
    logic [7:0] r_tail [3];
    logic [7:0] n_tail [3];
    logic [1:0] r_left, n_left;
    logic [6:0] r_crc, n_crc;
    logic       r_out_valid;
    t_beat      r_out;

    t_action     act;
    logic        is_cmd;
    logic [7:0]  head;
    logic [7:0]  fr [3];
    logic [1:0]  fr_left;
    logic        neg;
    logic [12:0] mag_abs;
    logic [12:0] mag;
    logic        out_free;
    logic        fire;
    t_beat       beat;

    assign act      = t_action'(i_item.action);
    assign neg      = i_item.speed[12];
    assign mag_abs  = neg ? (~i_item.speed + 13'd1) : i_item.speed;
    assign mag      = (mag_abs > SPEED_MAX) ? SPEED_MAX : mag_abs;
    assign out_free = !r_out_valid || i_beat_ready;

    // Encode the command: first byte plus up to three following bytes.
    always_comb begin
        is_cmd  = 1'b1;
        head    = CMD_STOP;
        fr[0]   = '0;
        fr[1]   = '0;
        fr[2]   = '0;
        fr_left = 2'd0;
        case (act)
            ACT_EXIT_SAFE: begin
                head = CMD_EXIT_SAFE;
            end
            ACT_SET_SPEED: begin
                head    = neg ? CMD_REV : CMD_FWD;
                fr[0]   = {3'd0, mag[4:0]};
                fr[1]   = {1'b0, mag[11:5]};
                fr_left = 2'd2;
            end
            ACT_STOP: begin
                head = CMD_STOP;
            end
            ACT_READ_VAR: begin
                head    = CMD_READ_VAR;
                fr[0]   = {1'b0, i_item.var_num};
                fr_left = 2'd1;
            end
            ACT_SET_LIMIT: begin
                head    = CMD_SET_LIMIT;
                fr[0]   = {4'd0, i_item.lim_num};
                fr[1]   = {1'b0, i_item.limit_value[6:0]};
                fr[2]   = {1'b0, i_item.limit_value[13:7]};
                fr_left = 2'd3;
            end
            default: begin
                is_cmd = 1'b0;
            end
        endcase
    end

    assign o_take = i_item_valid && (r_state == EM_IDLE) &&
                    (out_free || !(is_cmd || i_reply.has_beat));
    assign o_busy = (r_state != EM_IDLE);

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            EM_IDLE: begin
                if (o_take && is_cmd) begin
                    n_state = (fr_left == 2'd0) ? EM_TAIL : EM_BODY;
                end
            end
            EM_BODY: begin
                if (out_free && (r_left == 2'd1)) begin
                    n_state = EM_TAIL;
                end
            end
            EM_TAIL: begin
                if (out_free) begin
                    n_state = EM_IDLE;
                end
            end
            default: begin
                n_state = EM_IDLE;
            end
        endcase
    end

    // Beat selection and datapath updates.
    always_comb begin
        fire      = 1'b0;
        beat      = '{kind: KIND_TX, tx_byte: '0, last: 1'b0, reply_value: '0,
                      status: STAT_OK};
        n_crc     = r_crc;
        n_left    = r_left;
        n_tail[0] = r_tail[0];
        n_tail[1] = r_tail[1];
        n_tail[2] = r_tail[2];
        case (r_state)
            EM_IDLE: begin
                if (o_take && is_cmd) begin
                    fire         = 1'b1;
                    beat.tx_byte = head;
                    n_crc        = crc7_step(7'd0, head);
                    n_left       = fr_left;
                    n_tail[0]    = fr[0];
                    n_tail[1]    = fr[1];
                    n_tail[2]    = fr[2];
                end else if (o_take && i_reply.has_beat) begin
                    fire             = 1'b1;
                    beat.kind        = i_reply.kind;
                    beat.last        = 1'b1;
                    beat.reply_value = i_reply.value;
                    beat.status      = i_reply.status;
                end
            end
            EM_BODY: begin
                if (out_free) begin
                    fire         = 1'b1;
                    beat.tx_byte = r_tail[0];
                    n_crc        = crc7_step(r_crc, r_tail[0]);
                    n_left       = r_left - 2'd1;
                    n_tail[0]    = r_tail[1];
                    n_tail[1]    = r_tail[2];
                    n_tail[2]    = '0;
                end
            end
            EM_TAIL: begin
                if (out_free) begin
                    fire         = 1'b1;
                    beat.tx_byte = {1'b0, r_crc};
                    beat.last    = 1'b1;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= EM_IDLE;
            r_left      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_left  <= n_left;
            if (fire) begin
                r_out_valid <= 1'b1;
            end else if (i_beat_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_crc  <= n_crc;
        r_tail <= n_tail;
        if (fire) begin
            r_out <= beat;
        end
    end

    assign o_beat_valid = r_out_valid;
    assign o_beat       = r_out;

endmodule
